FILE: src/fpn_pkg.sv
// Shared types, constants and helpers for the fractal gradient noise block.
// No dependencies; imported by the top, front and back modules of the block.
package fpn_pkg;

	// Permutation table geometry
	localparam int PERM_W     = 8;
	localparam int PERM_DEPTH = 256;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Default octave limit
	localparam int MAX_OCTAVES_DEF = 8;

	// Frequency is unsigned Q24.16 held modulo 2^40
	localparam int FREQ_W   = 40;
	localparam int FADE_ONE = 65536;

	// Noise value and corner values, signed
	localparam int VAL_W = 20;

	// Configuration reset values
	localparam logic [3:0]  OCT_RST  = 4'd4;
	localparam logic [15:0] LAC_RST  = 16'd8192;
	localparam logic [15:0] PERS_RST = 16'd32768;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_OCTAVES = 2'd0,
		REG_LACUN   = 2'd1,
		REG_PERSIST = 2'd2
	} reg_idx_t;

	// One queued command
	typedef struct packed {
		cmd_t              cmd;
		logic [7:0]        table_index;
		logic [7:0]        table_value;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
	} item_t;

	// Corner gradient dot product, one of four diagonals
	function automatic logic signed [VAL_W-1:0] corner_dot(
		input logic [1:0]              h,
		input logic signed [VAL_W-1:0] dx,
		input logic signed [VAL_W-1:0] dy
	);
		logic signed [VAL_W-1:0] r;
		unique case (h)
			2'd0:    r = dx + dy;
			2'd1:    r = dy - dx;
			2'd2:    r = dx - dy;
			default: r = -dx - dy;
		endcase
		return r;
	endfunction

endpackage

FILE: src/fractal_perlin_noise_2d_top.sv
// A load is written to the table when the back end pops it; an evaluation runs, per
// octave, table lookups (which dominate, through the single RAM read port) and the
// fade/lerp datapath, then an iterative division and an output state.
// Throughput: one evaluation at a time; a two-beat command queue keeps start open
// meanwhile. Reset clears control state and config; the table is undefined until loaded.
// The receiver cannot stall: result_valid is a one-cycle strobe.
module fractal_perlin_noise_2d_top
	import fpn_pkg::*;
#(
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               result_valid,
	output logic signed [15:0] noise_value
);

	logic        q_valid;
	item_t       q_item;
	logic        q_pop;
	logic [3:0]  octave_count_q;
	logic [15:0] lacunarity_q;
	logic [15:0] persistence_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCT_RST;
			lacunarity_q   <= LAC_RST;
			persistence_q  <= PERS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OCTAVES: octave_count_q <= cfg_data[3:0];
				REG_LACUN:   lacunarity_q   <= cfg_data;
				REG_PERSIST: persistence_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	fpn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.table_index(table_index),
		.table_value(table_value),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	fpn_back #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.octave_count     (octave_count_q),
		.lacunarity_q4_12 (lacunarity_q),
		.persistence_q0_16(persistence_q),
		.result_valid     (result_valid),
		.noise_value      (noise_value)
	);

endmodule

FILE: src/fpn_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module fpn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/fpn_front.sv
// Front end: accepts command beats and queues them for the back end.
// Depends on fpn_pkg.
module fpn_front
	import fpn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               q_valid,
	output item_t              q_item,
	input  logic               q_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	item_t            new_item;

	assign busy    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];

	// classify the beat
	always_comb begin
		new_item.cmd         = command ? CMD_EVAL : CMD_LOAD;
		new_item.table_index = table_index;
		new_item.table_value = table_value;
		new_item.x_coord     = x_coord;
		new_item.y_coord     = y_coord;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/fpn_back.sv
// Back end: octave sequencer, table lookups, fade/lerp datapath, final divider.
// Depends on fpn_pkg and fpn_ram.
module fpn_back
	import fpn_pkg::*;
#(
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	input  logic [3:0]         octave_count,
	input  logic [15:0]        lacunarity_q4_12,
	input  logic [15:0]        persistence_q0_16,
	output logic               result_valid,
	output logic signed [15:0] noise_value
);

	localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
	localparam int ACC_W = 38 + OCT_W;
	localparam int WGT_W = 17 + OCT_W;
	localparam int DEN_W = WGT_W + 2;
	localparam int DCT_W = $clog2(ACC_W + 1);
	localparam int AW    = $clog2(PERM_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_F1, S_F2, S_F3, S_READ, S_DOT, S_DIF,
		S_L1, S_DIF2, S_L2, S_ACC, S_UPD, S_DSET, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	logic signed [31:0]       x_q, y_q;
	logic [FREQ_W-1:0]        freq_q;
	logic [16:0]              amp_q;
	logic [OCT_W-1:0]         oct_left_q;
	logic [FREQ_W-1:0]        xs_q, ys_q;
	logic [15:0]              t2x_q, t2y_q, t3x_q, t3y_q;
	logic [20:0]              inx_q, iny_q;
	logic [16:0]              u_q, v_q;
	logic [2:0]               rd_step_q;
	logic [PERM_W-1:0]        px0_q, px1_q, h00_q, h10_q, h01_q, h11_q;
	logic signed [VAL_W-1:0]  d00_q, d10_q, d01_q, d11_q;
	logic signed [VAL_W-1:0]  dft_q, dfb_q, top_q, bot_q, dfv_q, nv_q;
	logic signed [37:0]       nvprod_q;
	logic [47:0]              fplo_q;
	logic [23:0]              fphi_q;
	logic signed [ACC_W-1:0]  total_q;
	logic [WGT_W-1:0]         weight_q;
	logic                     neg_q;
	logic [ACC_W-1:0]         quo_q;
	logic [DEN_W-1:0]         rem_q, den_q;
	logic [DCT_W-1:0]         div_cnt_q;

	// octave count clamp
	logic [OCT_W-1:0] n_eff;
	always_comb begin
		if (octave_count == 4'd0) begin
			n_eff = OCT_W'(1);
		end else if (int'(octave_count) > MAX_OCTAVES) begin
			n_eff = OCT_W'(MAX_OCTAVES);
		end else begin
			n_eff = OCT_W'(octave_count);
		end
	end

	// scaled coordinates, modulo 2^40
	logic [63:0]       mx_lo, my_lo;
	logic [15:0]       mx_hi, my_hi;
	logic [FREQ_W-1:0] xs_d, ys_d;
	always_comb begin
		mx_lo = 64'(x_q) * 64'(freq_q[31:0]);
		my_lo = 64'(y_q) * 64'(freq_q[31:0]);
		mx_hi = 16'(x_q[7:0]) * 16'(freq_q[39:32]);
		my_hi = 16'(y_q[7:0]) * 16'(freq_q[39:32]);
		xs_d  = mx_lo[FREQ_W-1:0] + {mx_hi[7:0], 32'd0};
		ys_d  = my_lo[FREQ_W-1:0] + {my_hi[7:0], 32'd0};
	end

	logic [7:0]  xi, yi;
	logic [15:0] xf, yf;
	assign xi = xs_q[39:32];
	assign yi = ys_q[39:32];
	assign xf = xs_q[31:16];
	assign yf = ys_q[31:16];

	// fade stages
	logic [31:0]        sqx, sqy, cbx, cby;
	logic signed [23:0] ix, iy;
	logic [36:0]        fpx, fpy;
	always_comb begin
		sqx = 32'(xf) * 32'(xf);
		sqy = 32'(yf) * 32'(yf);
		cbx = 32'(t2x_q) * 32'(xf);
		cby = 32'(t2y_q) * 32'(yf);
		ix  = $signed({8'd0, t2x_q}) * 24'sd6 - $signed({8'd0, xf}) * 24'sd15 + 24'sd655360;
		iy  = $signed({8'd0, t2y_q}) * 24'sd6 - $signed({8'd0, yf}) * 24'sd15 + 24'sd655360;
		fpx = 37'(t3x_q) * 37'(inx_q);
		fpy = 37'(t3y_q) * 37'(iny_q);
	end

	// table read address sequence
	logic [AW-1:0]     raddr;
	logic [PERM_W-1:0] rdata;
	logic              ram_we;
	always_comb begin
		unique case (rd_step_q)
			3'd0:    raddr = xi;
			3'd1:    raddr = xi + 8'd1;
			3'd2:    raddr = px0_q + yi;
			3'd3:    raddr = px1_q + yi;
			3'd4:    raddr = px0_q + yi + 8'd1;
			3'd5:    raddr = px1_q + yi + 8'd1;
			default: raddr = '0;
		endcase
	end

	assign q_pop  = (state_q == S_IDLE) && q_valid;
	assign ram_we = q_pop && (q_item.cmd == CMD_LOAD);

	fpn_ram #(
		.WIDTH(PERM_W),
		.DEPTH(PERM_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_item.table_index),
		.wdata(q_item.table_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// corner offsets
	logic signed [VAL_W-1:0] dx0, dx1, dy0, dy1;
	assign dx0 = $signed(VAL_W'(xf));
	assign dy0 = $signed(VAL_W'(yf));
	assign dx1 = dx0 - VAL_W'(FADE_ONE);
	assign dy1 = dy0 - VAL_W'(FADE_ONE);

	// lerp products
	logic signed [37:0] lp_top, lp_bot, lp_v;
	always_comb begin
		lp_top = $signed({1'b0, u_q}) * dft_q;
		lp_bot = $signed({1'b0, u_q}) * dfb_q;
		lp_v   = $signed({1'b0, v_q}) * dfv_q;
	end

	// next frequency and amplitude
	logic [55:0] fsum;
	logic [32:0] aprod;
	assign fsum  = {fphi_q, 32'd0} + {8'd0, fplo_q};
	assign aprod = 33'(amp_q) * 33'(persistence_q0_16);

	// divider step
	logic [DEN_W:0] shifted;
	logic           qbit;
	assign shifted = {rem_q, quo_q[ACC_W-1]};
	assign qbit    = (shifted >= {1'b0, den_q});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			rd_step_q    <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && q_item.cmd == CMD_EVAL) begin
						x_q        <= q_item.x_coord;
						y_q        <= q_item.y_coord;
						freq_q     <= FREQ_W'(FADE_ONE);
						amp_q      <= 17'(FADE_ONE);
						oct_left_q <= n_eff;
						total_q    <= '0;
						weight_q   <= '0;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					xs_q    <= xs_d;
					ys_q    <= ys_d;
					state_q <= S_F1;
				end
				S_F1: begin
					t2x_q   <= sqx[31:16];
					t2y_q   <= sqy[31:16];
					state_q <= S_F2;
				end
				S_F2: begin
					t3x_q   <= cbx[31:16];
					t3y_q   <= cby[31:16];
					inx_q   <= ix[23] ? '0 : ix[20:0];
					iny_q   <= iy[23] ? '0 : iy[20:0];
					state_q <= S_F3;
				end
				S_F3: begin
					u_q       <= (fpx[36:16] > 21'(FADE_ONE)) ? 17'(FADE_ONE) : fpx[32:16];
					v_q       <= (fpy[36:16] > 21'(FADE_ONE)) ? 17'(FADE_ONE) : fpy[32:16];
					rd_step_q <= '0;
					state_q   <= S_READ;
				end
				S_READ: begin
					unique case (rd_step_q)
						3'd1:    px0_q <= rdata;
						3'd2:    px1_q <= rdata;
						3'd3:    h00_q <= rdata;
						3'd4:    h10_q <= rdata;
						3'd5:    h01_q <= rdata;
						3'd6:    h11_q <= rdata;
						default: ;
					endcase
					if (rd_step_q == 3'd6) begin
						rd_step_q <= '0;
						state_q   <= S_DOT;
					end else begin
						rd_step_q <= rd_step_q + 3'd1;
					end
				end
				S_DOT: begin
					d00_q   <= corner_dot(h00_q[1:0], dx0, dy0);
					d10_q   <= corner_dot(h10_q[1:0], dx1, dy0);
					d01_q   <= corner_dot(h01_q[1:0], dx0, dy1);
					d11_q   <= corner_dot(h11_q[1:0], dx1, dy1);
					state_q <= S_DIF;
				end
				S_DIF: begin
					dft_q   <= d10_q - d00_q;
					dfb_q   <= d11_q - d01_q;
					state_q <= S_L1;
				end
				S_L1: begin
					top_q   <= d00_q + VAL_W'(lp_top >>> 16);
					bot_q   <= d01_q + VAL_W'(lp_bot >>> 16);
					state_q <= S_DIF2;
				end
				S_DIF2: begin
					dfv_q   <= bot_q - top_q;
					state_q <= S_L2;
				end
				S_L2: begin
					nv_q    <= top_q + VAL_W'(lp_v >>> 16);
					state_q <= S_ACC;
				end
				S_ACC: begin
					nvprod_q <= nv_q * $signed({1'b0, amp_q});
					fplo_q   <= 48'(freq_q[31:0]) * 48'(lacunarity_q4_12);
					fphi_q   <= 24'(freq_q[39:32]) * 24'(lacunarity_q4_12);
					state_q  <= S_UPD;
				end
				S_UPD: begin
					total_q    <= total_q + ACC_W'(nvprod_q);
					weight_q   <= weight_q + WGT_W'(amp_q);
					amp_q      <= aprod[32:16];
					freq_q     <= fsum[51:12];
					oct_left_q <= oct_left_q - 1'b1;
					state_q    <= (oct_left_q == OCT_W'(1)) ? S_DSET : S_MUL;
				end
				S_DSET: begin
					neg_q     <= total_q[ACC_W-1];
					quo_q     <= total_q[ACC_W-1] ? ACC_W'(-total_q) : ACC_W'(total_q);
					rem_q     <= '0;
					den_q     <= {weight_q, 2'b00};
					div_cnt_q <= DCT_W'(ACC_W);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= qbit ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
					quo_q     <= {quo_q[ACC_W-2:0], qbit};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DCT_W'(1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (neg_q) begin
						noise_value <= (quo_q > ACC_W'(32768)) ? 16'sh8000 : 16'(-quo_q);
					end else begin
						noise_value <= (quo_q > ACC_W'(32767)) ? 16'sh7FFF : 16'(quo_q);
					end
					result_valid <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
